// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence at the same edge.
`define ACC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence at the next edge.
`define ACC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- sv/acc_pkg.sv -----
// Types and constants of the atom contact counter.
package acc_pkg;
  localparam int unsigned CUTOFF_W = 40;
  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 40'd589824;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned CNT_W = 10;
  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LOAD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_OUT
  } state_t;
endpackage

// ----- sv/atom_contact_counter_unit.sv -----
// Atom contact counter: appends atoms and counts close same-chain contacts.
// A load beat scans every stored atom through a three-cell compare chain, one
// stored atom entering the chain per cycle, and its count pass reuses the counts
// memory port once per atom. Read, clear and unused opcodes answer without a
// scan. The result is held in an output register; the next beat is taken once
// it has been delivered.
module atom_contact_counter_unit import acc_pkg::*; #(
  parameter int unsigned MAX_ATOMS  = 1024,
  parameter int unsigned COORD_BITS = 19
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CUTOFF_W-1:0]  cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // opcode, coord_x, coord_y, coord_z, chain_tag, residue_tag, query_index
  input  logic [((2+3*COORD_BITS+34)+7)/8*8-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // atom_slot, neighbor_count, status
  output logic [23:0]          out_tdata
);
  localparam int unsigned AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned NW = $clog2(MAX_ATOMS + 1);
  localparam int unsigned SW = 2 * COORD_BITS + 3;
  localparam int unsigned LAT = 3;
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned CMPW = (SW > CUTOFF_W) ? SW : CUTOFF_W;

  logic [CUTOFF_W-1:0] cutoff_r;
  state_t state_r, state_nxt;
  logic [NW-1:0] loaded_r, loaded_nxt;
  logic [NW-1:0] scan_r, scan_nxt;
  logic [LAT:0] vpipe_r;
  logic [AW-1:0] ipipe_r [LAT+1];
  logic [CNT_W-1:0] newcnt_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic [CNT_W-1:0] o_cnt_r;
  status_t o_st_r;
  logic out_v_r;
  logic [1:0] wait_r;
  logic [SLOT_W-1:0] q_r;
  logic [1:0] op_r;
  logic full_r;

  logic [3*CB-1:0] coords_mem [MAX_ATOMS];
  logic [23:0]     tags_mem   [MAX_ATOMS];
  logic [CNT_W-1:0] cnt_mem   [MAX_ATOMS];
  logic [3*CB-1:0] crd_rd;
  logic [23:0]     tag_rd;
  logic [CNT_W-1:0] cnt_rd;

  logic signed [CB-1:0] nx_r, ny_r, nz_r;
  logic [7:0] nchain_r;
  logic [15:0] nres_r;
  logic [1:0] op;
  logic [SLOT_W-1:0] q;
  logic acc;
  logic [SW-1:0] s0, s2;
  logic tagok_r [1:LAT];
  logic hit;

  assign op  = in_tdata[1:0];
  assign q   = in_tdata[2+3*CB+24 +: SLOT_W];
  assign acc = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cutoff_r <= CUTOFF_RESET;
    else if (cfg_we) cutoff_r <= cfg_wdata;
  end

  // scan address: during S_SCAN stream stored atoms; otherwise read query slot
  logic [AW-1:0] rd_addr;
  always_comb begin
    rd_addr = (state_r == S_SCAN) ? scan_r[AW-1:0] : AW'(q_r);
  end

  always_ff @(posedge clk) begin
    crd_rd <= coords_mem[rd_addr];
    tag_rd <= tags_mem[rd_addr];
  end

  // count memory: read at stage LAT-1 (else the query slot), write back bumped counts at pipe end, new count in S_DRAIN
  logic [AW-1:0] cnt_raddr;
  assign cnt_raddr = vpipe_r[LAT-1] ? ipipe_r[LAT-1] : AW'(q_r);
  always_ff @(posedge clk) begin
    cnt_rd <= cnt_mem[cnt_raddr];
    if (vpipe_r[LAT] && hit)
      cnt_mem[ipipe_r[LAT]] <= (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
    else if (state_r == S_DRAIN && vpipe_r == '0 && wait_r == 2'd0)
      cnt_mem[loaded_r[AW-1:0]] <= newcnt_r;
  end

  // tags are stored chain in the upper byte, residue below it
  always_ff @(posedge clk) begin
    if (acc && opcode_t'(op) == OP_LOAD && loaded_r != NW'(MAX_ATOMS)) begin
      coords_mem[loaded_r[AW-1:0]] <= in_tdata[2 +: 3*CB];
      tags_mem[loaded_r[AW-1:0]]   <= {in_tdata[2+3*CB +: 8], in_tdata[2+3*CB+8 +: 16]};
      nx_r <= in_tdata[2 +: CB];
      ny_r <= in_tdata[2+CB +: CB];
      nz_r <= in_tdata[2+2*CB +: CB];
      nchain_r <= in_tdata[2+3*CB +: 8];
      nres_r   <= in_tdata[2+3*CB+8 +: 16];
    end
  end

  // compare chain
  assign s0 = '0;
  logic [SW-1:0] c0, c1;
  acc_cell #(.CW(CB), .SW(SW)) u_cx (.clk(clk), .a_i(crd_rd[CB-1:0]), .b_i(nx_r),
    .sum_i(s0), .sum_o(c0));
  logic signed [CB-1:0] y_d, z_d, z_dd;
  always_ff @(posedge clk) begin
    y_d <= crd_rd[CB +: CB];
    z_d <= crd_rd[2*CB +: CB];
    z_dd <= z_d;
  end
  acc_cell #(.CW(CB), .SW(SW)) u_cy (.clk(clk), .a_i(y_d), .b_i(ny_r),
    .sum_i(c0), .sum_o(c1));
  acc_cell #(.CW(CB), .SW(SW)) u_cz (.clk(clk), .a_i(z_dd), .b_i(nz_r),
    .sum_i(c1), .sum_o(s2));

  // stage 0 is memory read; tags compared there
  always_ff @(posedge clk) begin
    tagok_r[1] <= (tag_rd[23:16] == nchain_r) && (tag_rd[15:0] != nres_r);
    for (int k = 2; k <= LAT; k++) tagok_r[k] <= tagok_r[k-1];
    ipipe_r[0] <= scan_r[AW-1:0];
    for (int k = 1; k <= LAT; k++) ipipe_r[k] <= ipipe_r[k-1];
  end
  assign hit = tagok_r[LAT] && (CMPW'(s2) <= CMPW'(cutoff_r));

  always_comb begin
    state_nxt = state_r;
    scan_nxt = scan_r;
    loaded_nxt = loaded_r;
    case (state_r)
      S_IDLE: if (acc) begin
        if (opcode_t'(op) == OP_LOAD && loaded_r != NW'(MAX_ATOMS)) begin
          state_nxt = (loaded_r == '0) ? S_DRAIN : S_SCAN;
          scan_nxt = '0;
        end else begin
          state_nxt = S_OUT;
          if (opcode_t'(op) == OP_CLEAR) loaded_nxt = '0;
        end
      end
      S_SCAN: begin
        scan_nxt = scan_r + 1'b1;
        if (scan_r + 1'b1 == loaded_r) state_nxt = S_DRAIN;
      end
      S_DRAIN: if (vpipe_r == '0 && wait_r == 2'd0) begin
        loaded_nxt = loaded_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_OUT: if (wait_r == 2'd0) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      loaded_r <= '0;
      scan_r <= '0;
      vpipe_r <= '0;
      out_v_r <= 1'b0;
      wait_r <= '0;
    end else begin
      state_r <= state_nxt;
      loaded_r <= loaded_nxt;
      scan_r <= scan_nxt;
      vpipe_r <= {vpipe_r[LAT-1:0], state_r == S_SCAN};
      if (acc) wait_r <= 2'd1;
      else if (wait_r != 2'd0) wait_r <= wait_r - 1'b1;
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (state_r == S_DRAIN && vpipe_r == '0 && wait_r == 2'd0) out_v_r <= 1'b1;
      if (state_r == S_OUT && wait_r == 2'd0) out_v_r <= 1'b1;
    end
  end

  // payload of the result and running count of the new atom
  always_ff @(posedge clk) begin
    if (acc) begin
      q_r <= q;
      op_r <= op;
      full_r <= loaded_r == NW'(MAX_ATOMS);
      newcnt_r <= '0;
    end else if (vpipe_r[LAT] && hit && newcnt_r != COUNT_MAX) begin
      newcnt_r <= newcnt_r + 1'b1;
    end
    if (state_r == S_DRAIN) begin
      o_slot_r <= SLOT_W'(loaded_r);
      o_cnt_r <= newcnt_r;
      o_st_r <= ST_OK;
    end else if (state_r == S_OUT) begin
      o_slot_r <= '0;
      o_cnt_r <= '0;
      o_st_r <= ST_OK;
      case (opcode_t'(op_r))
        OP_LOAD: o_st_r <= full_r ? ST_FULL : ST_OK;
        OP_READ: begin
          o_slot_r <= q_r;
          if (NW'(q_r) < loaded_r && 32'(q_r) < MAX_ATOMS) o_cnt_r <= cnt_rd;
          else o_st_r <= ST_NOT_LOAD;
        end
        default: o_st_r <= ST_OK;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {2'b00, o_st_r, o_cnt_r, o_slot_r};
endmodule

// ----- sv/acc_cell.sv -----
// One cell of the compare chain: squares one coordinate difference and adds it.
module acc_cell import acc_pkg::*; #(
  parameter int unsigned CW = 19,
  parameter int unsigned SW = 2 * CW + 2
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] a_i,
  input  logic signed [CW-1:0] b_i,
  input  logic        [SW-1:0] sum_i,
  output logic        [SW-1:0] sum_o
);
  logic signed [CW:0]     diff;
  logic        [CW:0]     mag;
  logic        [2*CW+1:0] sq;
  logic        [SW-1:0]   sum_r;

  always_comb begin
    diff = $signed({a_i[CW-1], a_i}) - $signed({b_i[CW-1], b_i});
    mag  = diff[CW] ? (CW+1)'(-diff) : diff;
    sq   = (2*CW+2)'(mag) * (2*CW+2)'(mag);
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_i + SW'(sq);
  end
  assign sum_o = sum_r;
endmodule

// ----- sv/acc_checker.sv -----
// Port-level checker for the atom contact counter, bound to the top level.
`include "assert_macros.svh"
module acc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [23:0] out_tdata
);
  `ACC_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ACC_ASSERT_IMPL(a_noacc, clk, rst_n, out_tvalid, !in_tready)
  `ACC_ASSERT_IMPL(a_stat, clk, rst_n, out_tvalid, out_tdata[21:20] != 2'd3)
  `ACC_ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
endmodule

bind atom_contact_counter_unit acc_checker u_acc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the atom contact counter unit.
`timescale 1ns / 1ps

module tb;
  import acc_pkg::*;

  localparam int unsigned NATOMS = 1024;
  localparam int unsigned CB = 19;
  localparam int unsigned WATCH_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic [7:0]          chain;
    logic [15:0]         res;
    logic [9:0]          q;
  } atom_cmd_t;

  typedef struct packed {
    logic [9:0] slot;
    logic [9:0] count;
    logic [1:0] status;
  } answer_t;

  typedef struct packed {
    atom_cmd_t cmd;
    logic      fixed;
    answer_t   ans;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CUTOFF_W-1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [95:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;

  atom_contact_counter_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state
  logic signed [CB-1:0] px[NATOMS], py[NATOMS], pz[NATOMS];
  logic [7:0]  pchain[NATOMS];
  logic [15:0] pres[NATOMS];
  logic [9:0]  pcount[NATOMS];
  int unsigned natoms;
  logic [CUTOFF_W-1:0] cutoff;

  answer_t pending_answers[$];
  int unsigned errors;
  bit burst;      // no idling on either side while set
  bit hold_req;   // ask the receiver for one long stall
  int unsigned idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned sq(longint signed a, longint signed b);
    longint signed d;
    d = a - b;
    return d * d;
  endfunction

  // Apply one command to the predictor and return the answer it gives.
  function automatic answer_t count_contacts(atom_cmd_t c);
    answer_t a;
    longint unsigned d2;
    int unsigned n;
    a = '0;
    case (c.op)
      OP_LOAD: begin
        if (natoms >= NATOMS) begin
          a.status = ST_FULL;
        end else begin
          n = natoms;
          px[n] = c.x; py[n] = c.y; pz[n] = c.z;
          pchain[n] = c.chain; pres[n] = c.res; pcount[n] = '0;
          for (int i = 0; i < n; i++) begin
            if (pchain[i] == c.chain && pres[i] != c.res) begin
              d2 = sq(px[i], c.x) + sq(py[i], c.y) + sq(pz[i], c.z);
              if (d2 <= cutoff) begin
                if (pcount[i] != COUNT_MAX) pcount[i]++;
                if (pcount[n] != COUNT_MAX) pcount[n]++;
              end
            end
          end
          natoms = n + 1;
          a.slot = n[9:0];
          a.count = pcount[n];
        end
      end
      OP_READ: begin
        a.slot = c.q;
        if (c.q < natoms) a.count = pcount[c.q];
        else a.status = ST_NOT_LOAD;
      end
      OP_CLEAR: natoms = 0;
      default: ;
    endcase
    return a;
  endfunction

  function automatic int unsigned draw_gap();
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  // Offer one beat; record its expectation at the accepting edge.
  task automatic send_cmd(atom_cmd_t c, bit fixed, answer_t typed);
    int unsigned gap;
    answer_t a;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b0, c.q, c.res, c.chain, c.z, c.y, c.x, c.op};
    do @(posedge clk); while (!in_tready);
    a = count_contacts(c);
    pending_answers.push_back(fixed ? typed : a);
  endtask

  task automatic write_cutoff(logic [CUTOFF_W-1:0] v);
    in_tvalid <= 1'b0;
    wait (pending_answers.size() == 0);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cutoff = v;
  endtask

  function automatic atom_cmd_t random_cmd(logic signed [CB-1:0] cx, logic signed [CB-1:0] cy,
                                           logic signed [CB-1:0] cz);
    atom_cmd_t c;
    int unsigned r;
    c = '0;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // noise: every field random, though an out-of-range read slot may be folded back
      c = atom_cmd_t'(($bits(atom_cmd_t))'({$urandom(), $urandom(), $urandom()}));
      if (c.op == OP_READ && c.q >= natoms && $urandom_range(0, 1))
        c.q = 10'(c.q % (natoms + 1));
    end else if (r < 64) begin
      c.op = OP_LOAD;
      c.x = CB'(cx + $signed($urandom_range(0, 1200)) - 600);
      c.y = CB'(cy + $signed($urandom_range(0, 1200)) - 600);
      c.z = CB'(cz + $signed($urandom_range(0, 1200)) - 600);
      c.chain = 8'($urandom_range(0, 2));
      c.res = 16'($urandom_range(0, 3));
    end else if (r < 93) begin
      c.op = OP_READ;
      c.q = 10'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                          : $urandom_range(0, natoms + 1));
    end else if (r < 97) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OP_NONE;
      c.q = 10'($urandom());
    end
    return c;
  endfunction

  task automatic random_phase(int unsigned count);
    logic signed [CB-1:0] cx, cy, cz;
    for (int k = 0; k < count; k++) begin
      if (k % 30 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
        cx = CB'($urandom()); cy = CB'($urandom()); cz = CB'($urandom());
      end
      send_cmd(random_cmd(cx, cy, cz), 1'b0, '0);
    end
  endtask

  localparam logic signed [CB-1:0] CMIN = -19'sd262144;
  localparam logic signed [CB-1:0] CMAX = 19'sd262143;

  dir_row_t dir_rows[17] = '{
    '{'{OP_READ, 0, 0, 0, 0, 0, 5}, 1'b1, '{10'd5, 10'd0, ST_NOT_LOAD}},
    '{'{OP_NONE, 0, 0, 0, 0, 0, 0}, 1'b1, '{10'd0, 10'd0, ST_OK}},
    '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0}, 1'b1, '{10'd0, 10'd0, ST_OK}},
    '{'{OP_LOAD, CMIN, CMIN, CMIN, 0, 0, 0}, 1'b1, '{10'd0, 10'd0, ST_OK}},
    '{'{OP_LOAD, CMIN, CMIN, CMIN, 0, 1, 0}, 1'b1, '{10'd1, 10'd1, ST_OK}},
    '{'{OP_LOAD, CMIN, CMIN, CMIN, 0, 0, 0}, 1'b0, '0},
    '{'{OP_LOAD, CMAX, CMAX, CMAX, 0, 2, 0}, 1'b1, '{10'd3, 10'd0, ST_OK}},
    '{'{OP_LOAD, CMAX, CMAX, CMAX, 8'd255, 16'd65535, 0}, 1'b1, '{10'd4, 10'd0, ST_OK}},
    '{'{OP_LOAD, CMAX - 256, CMAX, CMAX, 8'd255, 0, 0}, 1'b1, '{10'd5, 10'd1, ST_OK}},
    '{'{OP_READ, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
    '{'{OP_READ, 0, 0, 0, 0, 0, 4}, 1'b0, '0},
    '{'{OP_READ, 0, 0, 0, 0, 0, 10'd1023}, 1'b1, '{10'd1023, 10'd0, ST_NOT_LOAD}},
    // exactly on the cutoff, then one step beyond it
    '{'{OP_LOAD, CMIN + 768, CMIN, CMIN, 0, 5, 0}, 1'b0, '0},
    '{'{OP_LOAD, CMIN + 769, CMIN, CMIN, 0, 6, 0}, 1'b0, '0},
    '{'{OP_READ, 0, 0, 0, 0, 0, 6}, 1'b0, '0},
    '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0}, 1'b1, '{10'd0, 10'd0, ST_OK}},
    '{'{OP_READ, 0, 0, 0, 0, 0, 0}, 1'b1, '{10'd0, 10'd0, ST_NOT_LOAD}}
  };

  // receiver: random stalls, one long hold on request, checks each beat
  initial begin
    int unsigned gap;
    answer_t got, want;
    out_tready <= 1'b0;
    wait (rst_n);
    forever begin
      gap = draw_gap();
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = {out_tdata[9:0], out_tdata[19:10], out_tdata[21:20]};
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %h", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: slot %0d/%0d count %0d/%0d status %0d/%0d (exp/got)",
                     want.slot, got.slot, want.count, got.count, want.status, got.status);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat or config write
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    errors = 0;
    burst = 1'b0;
    hold_req = 1'b0;
    natoms = 0;
    cutoff = CUTOFF_RESET;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_cmd(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].ans);

    hold_req = 1'b1;
    random_phase(120);
    write_cutoff('0);
    random_phase(110);
    write_cutoff(CUTOFF_W'($urandom_range(0, 1 << 21)));
    random_phase(120);
    write_cutoff('1);
    random_phase(110);
    write_cutoff(CUTOFF_RESET);
    random_phase(120);
    in_tvalid <= 1'b0;

    wait (pending_answers.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
